// ===== src/flb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list block allocator package
// Shared widths, reset values, codes and transaction types of the allocator.
// ----------------------------------------------------------------------------
package flb_pkg;

    // Fixed widths of the transaction fields and configuration registers.
    localparam int FIELD_ADDR_W = 32;
    localparam int COUNT_FIELD_W = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ESIZE_W = 13;
    localparam int ALIGN_W = 4;
    localparam int POOL_W = 11;
    // Element size plus the largest alignment round-up fits in 16 bits.
    localparam int STRIDE_W = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_DEPTH = 1024;
    localparam int DEF_ADDR_WIDTH = 32;

    // Register values after reset.
    localparam logic [CFG_DATA_W-1:0] RST_BASE_ADDRESS = '0;
    localparam logic [ESIZE_W-1:0] RST_ELEMENT_SIZE = 13'd64;
    localparam logic [ALIGN_W-1:0] RST_ALIGN_LOG2 = 4'd3;
    localparam int RST_POOL_COUNT = 1024;
    // 64 bytes rounded up to 8-byte alignment.
    localparam logic [STRIDE_W-1:0] RST_STRIDE = 16'd64;

    // The null block address.
    localparam logic [FIELD_ADDR_W-1:0] NULL_ADDRESS = '0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS   = 3'd0,
        CFG_ELEMENT_SIZE   = 3'd1,
        CFG_ALIGNMENT_LOG2 = 3'd2,
        CFG_POOL_COUNT     = 3'd3
    } flb_cfg_idx_t;

    // Operation codes.
    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } flb_cmd_t;

    // Status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_POOL_EMPTY = 2'd1,
        STATUS_NULL_ADDR  = 2'd2,
        STATUS_LIST_FULL  = 2'd3
    } flb_status_t;

    // Request transaction.
    typedef struct packed {
        flb_cmd_t                cmd;
        logic [FIELD_ADDR_W-1:0] release_address;
    } flb_req_t;

    // Result transaction.
    typedef struct packed {
        logic [FIELD_ADDR_W-1:0]  block_address;
        flb_status_t              status;
        logic [COUNT_FIELD_W-1:0] acquired_count;
        logic [COUNT_FIELD_W-1:0] available_count;
        logic                     over_capacity;
    } flb_rsp_t;

    // Per-cell control of the free-list chain.
    typedef struct packed {
        logic load;   // Take the appended address.
        logic shift;  // Take the neighbor's entry (head popped).
    } flb_cell_ctl_t;

endpackage

// ===== src/flb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list cell
// One entry of the released-address chain. Shifts toward the head on a pop
// and captures the appended address when it is the first empty slot.
// ----------------------------------------------------------------------------
module flb_cell
    import flb_pkg::*;
#(
    parameter int DATA_W = DEF_ADDR_WIDTH
) (
    input  logic              clk,
    input  flb_cell_ctl_t     ctl,
    input  logic [DATA_W-1:0] load_data,
    input  logic [DATA_W-1:0] shift_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Pop and append never happen in the same cycle.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
        begin
            data_next = shift_data;
        end
        else if (ctl.load)
        begin
            data_next = load_data;
        end
    end

    // Entry storage; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/flb_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list allocator configuration
// Holds the configuration registers and, after a write, registers the block
// stride and the effective pool size derived from them.
// ----------------------------------------------------------------------------
module flb_cfg
    import flb_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  reinit,
    output logic [ADDR_WIDTH-1:0] base_address,
    output logic [STRIDE_W-1:0]   stride,
    output logic [CNT_W-1:0]      eff_count,
    output logic [CNT_W-1:0]      eff_count_next
);

    localparam int PC_W = (CNT_W > POOL_W) ? CNT_W : POOL_W;
    localparam int RST_EFF = (RST_POOL_COUNT > DEPTH) ? DEPTH : RST_POOL_COUNT;

    logic [ADDR_WIDTH-1:0] base_reg, base_next;
    logic [ESIZE_W-1:0]    esize_reg, esize_next;
    logic [ALIGN_W-1:0]    alog2_reg, alog2_next;
    logic [POOL_W-1:0]     pool_reg, pool_next;
    logic [STRIDE_W-1:0]   stride_reg, stride_next;
    logic [CNT_W-1:0]      eff_reg;
    logic                  pend_reg, pend_next;
    logic                  wr_en;
    logic [STRIDE_W-1:0]   align_mask;
    logic [STRIDE_W-1:0]   rounded_sum;
    logic [PC_W-1:0]       pool_ext;

    assign cfg_ready = !pend_reg;
    assign wr_en = cfg_valid && cfg_ready;

    // Register writes; only a known index frees the pool again.
    always_comb
    begin
        base_next = base_reg;
        esize_next = esize_reg;
        alog2_next = alog2_reg;
        pool_next = pool_reg;
        pend_next = 1'b0;
        if (wr_en)
        begin
            case (cfg_index)
                CFG_BASE_ADDRESS:
                begin
                    base_next = ADDR_WIDTH'(cfg_data);
                    pend_next = 1'b1;
                end
                CFG_ELEMENT_SIZE:
                begin
                    esize_next = cfg_data[ESIZE_W-1:0];
                    pend_next = 1'b1;
                end
                CFG_ALIGNMENT_LOG2:
                begin
                    alog2_next = cfg_data[ALIGN_W-1:0];
                    pend_next = 1'b1;
                end
                CFG_POOL_COUNT:
                begin
                    pool_next = cfg_data[POOL_W-1:0];
                    pend_next = 1'b1;
                end
                default:
                begin
                    pend_next = 1'b0;
                end
            endcase
        end
    end

    // Stride is the element size rounded up to the alignment.
    always_comb
    begin
        align_mask = {STRIDE_W{1'b1}} << alog2_reg;
        rounded_sum = STRIDE_W'(esize_reg) + ~align_mask;
        stride_next = rounded_sum & align_mask;
    end

    // Pool size is limited to the depth of the free list.
    always_comb
    begin
        pool_ext = PC_W'(pool_reg);
        if (pool_ext > PC_W'(DEPTH))
        begin
            eff_count_next = CNT_W'(DEPTH);
        end
        else
        begin
            eff_count_next = CNT_W'(pool_ext);
        end
    end

    // Configuration registers and derived values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= ADDR_WIDTH'(RST_BASE_ADDRESS);
            esize_reg <= RST_ELEMENT_SIZE;
            alog2_reg <= RST_ALIGN_LOG2;
            pool_reg <= POOL_W'(RST_POOL_COUNT);
            stride_reg <= RST_STRIDE;
            eff_reg <= CNT_W'(RST_EFF);
            pend_reg <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            esize_reg <= esize_next;
            alog2_reg <= alog2_next;
            pool_reg <= pool_next;
            pend_reg <= pend_next;
            if (pend_reg)
            begin
                stride_reg <= stride_next;
                eff_reg <= eff_count_next;
            end
        end
    end

    assign reinit = pend_reg;
    assign base_address = base_reg;
    assign stride = stride_reg;
    assign eff_count = eff_reg;

endmodule

// ===== src/free_list_block_allocator.sv =====
`timescale 1ns / 1ps
// The result strobe comes in the cycle after a command is accepted.
// Throughput: one command per cycle while busy is low; the counters and the head cell of the
// free-list chain settle within the cycle of acceptance.
// A configuration write holds busy high for one cycle while stride, pool size
// and the free pool are set up again.
// Reset: pool fully free from the reset base address; chain contents undefined.
// ----------------------------------------------------------------------------
// Free list block allocator
// Fixed-size block pool: fresh blocks are handed out first at the stride,
// released addresses follow in FIFO order through a chain of cells.
// ----------------------------------------------------------------------------
module free_list_block_allocator
    import flb_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  flb_req_t              request,
    output logic                  done,
    output flb_rsp_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RST_EFF = (RST_POOL_COUNT > DEPTH) ? DEPTH : RST_POOL_COUNT;

    logic                  reinit;
    logic [ADDR_WIDTH-1:0] base_address;
    logic [STRIDE_W-1:0]   stride;
    logic [CNT_W-1:0]      eff_count;
    logic [CNT_W-1:0]      eff_count_next;

    logic [CNT_W-1:0]      fresh_idx_reg, fresh_idx_next;
    logic [ADDR_WIDTH-1:0] fresh_addr_reg, fresh_addr_next;
    logic [CNT_W-1:0]      fifo_count_reg, fifo_count_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [CNT_W-1:0]      avail_reg, avail_next;
    logic                  done_reg;
    flb_rsp_t              result_reg, result_next;

    logic                  accept;
    logic                  pop;
    logic                  push;
    logic [ADDR_WIDTH-1:0] release_addr;
    logic [ADDR_WIDTH-1:0] cell_data [DEPTH];

    // Configuration registers and derived stride and pool size.
    flb_cfg #(
        .DEPTH     (DEPTH),
        .ADDR_WIDTH(ADDR_WIDTH),
        .CNT_W     (CNT_W)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .reinit        (reinit),
        .base_address  (base_address),
        .stride        (stride),
        .eff_count     (eff_count),
        .eff_count_next(eff_count_next)
    );

    assign busy = reinit;
    assign accept = start && !busy;
    assign release_addr = ADDR_WIDTH'(request.release_address);

    // Command decode and counter updates.
    always_comb
    begin
        fresh_idx_next = fresh_idx_reg;
        fresh_addr_next = fresh_addr_reg;
        fifo_count_next = fifo_count_reg;
        used_next = used_reg;
        avail_next = avail_reg;
        pop = 1'b0;
        push = 1'b0;
        result_next.block_address = NULL_ADDRESS;
        result_next.status = STATUS_OK;
        if (reinit)
        begin
            fresh_idx_next = '0;
            fresh_addr_next = base_address;
            fifo_count_next = '0;
            used_next = '0;
            avail_next = eff_count_next;
        end
        else if (accept)
        begin
            case (request.cmd)
                CMD_ACQUIRE:
                begin
                    if (fresh_idx_reg < eff_count)
                    begin
                        result_next.block_address = FIELD_ADDR_W'(fresh_addr_reg);
                        fresh_addr_next = fresh_addr_reg + ADDR_WIDTH'(stride);
                        fresh_idx_next = fresh_idx_reg + 1'b1;
                        used_next = used_reg + 1'b1;
                        avail_next = avail_reg - 1'b1;
                    end
                    else if (fifo_count_reg != '0)
                    begin
                        result_next.block_address = FIELD_ADDR_W'(cell_data[0]);
                        pop = 1'b1;
                        fifo_count_next = fifo_count_reg - 1'b1;
                        used_next = used_reg + 1'b1;
                        avail_next = avail_reg - 1'b1;
                    end
                    else
                    begin
                        result_next.status = STATUS_POOL_EMPTY;
                    end
                end
                CMD_RELEASE:
                begin
                    if (request.release_address == NULL_ADDRESS)
                    begin
                        result_next.status = STATUS_NULL_ADDR;
                    end
                    else if (used_reg == '0 || fifo_count_reg == CNT_W'(DEPTH))
                    begin
                        result_next.status = STATUS_LIST_FULL;
                    end
                    else
                    begin
                        push = 1'b1;
                        fifo_count_next = fifo_count_reg + 1'b1;
                        used_next = used_reg - 1'b1;
                        avail_next = avail_reg + 1'b1;
                    end
                end
                default:
                begin
                    result_next.status = STATUS_OK;
                end
            endcase
        end
        result_next.acquired_count = COUNT_FIELD_W'(used_next);
        result_next.available_count = COUNT_FIELD_W'(avail_next);
        result_next.over_capacity = (avail_next == '0);
    end

    // Chain of free-list cells; cell zero is the head of the FIFO.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        flb_cell_ctl_t           ctl;
        logic [ADDR_WIDTH-1:0] shift_data;

        assign ctl.load = push && (fifo_count_reg == CNT_W'(i));
        assign ctl.shift = pop;
        if (i == DEPTH - 1)
        begin : g_last
            assign shift_data = '0;
        end
        else
        begin : g_mid
            assign shift_data = cell_data[i + 1];
        end

        flb_cell #(
            .DATA_W(ADDR_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .load_data (release_addr),
            .shift_data(shift_data),
            .data      (cell_data[i])
        );
    end

    // Allocation state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_idx_reg <= '0;
            fresh_addr_reg <= ADDR_WIDTH'(RST_BASE_ADDRESS);
            fifo_count_reg <= '0;
            used_reg <= '0;
            avail_reg <= CNT_W'(RST_EFF);
            done_reg <= 1'b0;
        end
        else
        begin
            fresh_idx_reg <= fresh_idx_next;
            fresh_addr_reg <= fresh_addr_next;
            fifo_count_reg <= fifo_count_next;
            used_reg <= used_next;
            avail_reg <= avail_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

    // A result strobe follows exactly one accepted transaction.
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result strobe without an accepted transaction");

    // Setup after a configuration write lasts a single cycle.
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // Every managed block is either handed out or free.
    a_blocks_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, avail_reg} + {1'b0, used_reg}) == {1'b0, eff_count})
        else $error("handed-out and free block counts disagree with pool size");

    // The chain never holds more entries than it has cells.
    a_fifo_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= CNT_W'(DEPTH))
        else $error("free list count beyond depth");

endmodule
